/* sv/cset_pkg.sv */
// ----------------------------------------------------------------------------
// cset_pkg
// Shared constants, types and helpers for the cue schedule elapsed timer.
// ----------------------------------------------------------------------------
package cset_pkg;

    localparam int NUM_CUES = 8;
    localparam int CH_W     = 3;
    localparam int TIME_W   = 32;
    localparam int VAL_W    = TIME_W + 2;   // time minus cue start, with headroom
    localparam int X_W      = VAL_W + 1;    // value minus loop base
    localparam int SZ_W     = TIME_W + 1;   // loop span magnitude
    localparam int CNT_W    = $clog2(X_W);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 64;

    localparam logic [1:0] LM_NONE   = 2'd0;
    localparam logic [1:0] LM_WRAP   = 2'd1;
    localparam logic [1:0] LM_MIRROR = 2'd2;

    localparam logic [1:0] DM_SINGLE      = 2'd0;
    localparam logic [1:0] DM_UNTIL_NEXT  = 2'd1;
    localparam logic [1:0] DM_UNTIL_RESET = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CUE_12     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUE_34     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUE_56     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CUE_78     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUE_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUR_MODE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE  = 3'd6;

    typedef struct packed {
        logic                     start;
        logic signed [VAL_W-1:0]  value;
        logic signed [TIME_W-1:0] len;
        logic [1:0]               mode;
    } shape_cmd_t;

    typedef struct packed {
        logic                     done;
        logic signed [TIME_W-1:0] result;
    } shape_rsp_t;

    function automatic logic signed [TIME_W-1:0] sat32(input logic signed [X_W-1:0] v);
        logic signed [X_W-1:0] hi;
        logic signed [X_W-1:0] lo;
        hi = X_W'(33'sh0_7FFF_FFFF);
        lo = -hi - X_W'(1);
        if (v > hi) begin
            sat32 = {1'b0, {(TIME_W-1){1'b1}}};
        end else if (v < lo) begin
            sat32 = {1'b1, {(TIME_W-1){1'b0}}};
        end else begin
            sat32 = v[TIME_W-1:0];
        end
    endfunction

endpackage

/* sv/cset_shape_unit.sv */
// ----------------------------------------------------------------------------
// cset_shape_unit
// Loop shaping unit: pass-through, wrap or mirror of a time value against the
// loop length, using a bit-serial remainder (one bit per cycle), saturated.
// ----------------------------------------------------------------------------
module cset_shape_unit
    import cset_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  shape_cmd_t cmd,
    output shape_rsp_t rsp
);

    localparam logic [2:0] U_IDLE = 3'd0;
    localparam logic [2:0] U_PREP = 3'd1;
    localparam logic [2:0] U_DIV  = 3'd2;
    localparam logic [2:0] U_FIX  = 3'd3;
    localparam logic [2:0] U_FOLD = 3'd4;

    logic [2:0]               st_reg, st_next;
    logic                     done_reg, done_next;
    logic signed [VAL_W-1:0]  value_reg, value_next;
    logic signed [VAL_W-1:0]  len_reg, len_next;
    logic [1:0]               mode_reg, mode_next;
    logic signed [VAL_W-1:0]  m_reg, m_next;
    logic signed [VAL_W-1:0]  lo_reg, lo_next;
    logic [SZ_W-1:0]          size_reg, size_next;
    logic [X_W-1:0]           mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic [SZ_W-1:0]          rem_reg, rem_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [VAL_W-1:0]  w_reg, w_next;
    logic signed [TIME_W-1:0] result_reg, result_next;

    logic signed [VAL_W-1:0]  m_w;
    logic signed [X_W-1:0]    x_w;
    logic [SZ_W:0]            trial_w;
    logic [SZ_W-1:0]          r_w;
    logic signed [X_W-1:0]    fold_w;

    always_comb begin
        st_next     = st_reg;
        done_next   = 1'b0;
        value_next  = value_reg;
        len_next    = len_reg;
        mode_next   = mode_reg;
        m_next      = m_reg;
        lo_next     = lo_reg;
        size_next   = size_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        w_next      = w_reg;
        result_next = result_reg;

        m_w     = (mode_reg == LM_MIRROR) ? (len_reg <<< 1) : len_reg;
        x_w     = X_W'(value_reg) - ((m_w < 0) ? X_W'(m_w) : X_W'(0));
        trial_w = {rem_reg, mag_reg[X_W-1]};
        r_w     = (neg_reg && (rem_reg != '0)) ? (size_reg - rem_reg) : rem_reg;
        fold_w  = ((mode_reg == LM_MIRROR) && (w_reg > len_reg)) ?
                  (X_W'(m_reg) - X_W'(w_reg)) : X_W'(w_reg);

        case (st_reg)
            U_IDLE: begin
                if (cmd.start) begin
                    value_next = cmd.value;
                    len_next   = VAL_W'(cmd.len);
                    mode_next  = cmd.mode;
                    st_next    = U_PREP;
                end
            end
            U_PREP: begin
                if ((mode_reg != LM_WRAP) && (mode_reg != LM_MIRROR)) begin
                    result_next = sat32(X_W'(value_reg));
                    done_next   = 1'b1;
                    st_next     = U_IDLE;
                end else if (m_w == '0) begin
                    result_next = '0;
                    done_next   = 1'b1;
                    st_next     = U_IDLE;
                end else begin
                    m_next    = m_w;
                    lo_next   = (m_w < 0) ? m_w : '0;
                    size_next = (m_w < 0) ? SZ_W'(-m_w) : SZ_W'(m_w);
                    neg_next  = x_w < 0;
                    mag_next  = (x_w < 0) ? X_W'(-x_w) : X_W'(x_w);
                    rem_next  = '0;
                    cnt_next  = CNT_W'(X_W - 1);
                    st_next   = U_DIV;
                end
            end
            U_DIV: begin
                if (trial_w >= {1'b0, size_reg}) begin
                    rem_next = SZ_W'(trial_w - {1'b0, size_reg});
                end else begin
                    rem_next = trial_w[SZ_W-1:0];
                end
                mag_next = mag_reg << 1;
                if (cnt_reg == '0) begin
                    st_next = U_FIX;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            U_FIX: begin
                w_next  = lo_reg + $signed(VAL_W'(r_w));
                st_next = U_FOLD;
            end
            U_FOLD: begin
                result_next = sat32(fold_w);
                done_next   = 1'b1;
                st_next     = U_IDLE;
            end
            default: begin
                st_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= U_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
        value_reg  <= value_next;
        len_reg    <= len_next;
        mode_reg   <= mode_next;
        m_reg      <= m_next;
        lo_reg     <= lo_next;
        size_reg   <= size_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        w_reg      <= w_next;
        result_reg <= result_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

/* sv/cue_schedule_elapsed_timer_unit.sv */
// ----------------------------------------------------------------------------
// cue_schedule_elapsed_timer_unit
// Shapes each time sample by the loop mode, tracks per-cue started flags and
// emits channel and elapsed time for every cue that fires.
// ----------------------------------------------------------------------------
//  channel  | ports            | content
//  ---------+------------------+-------------------------------------------
//  input    | s_tvalid/tready  | s_tdata: time_value
//  result   | m_tvalid/tready  | m_tdata: channel, elapsed; m_tlast: last_of_run
//  config   | cfg_we           | cfg_index, cfg_wdata
//
//  The loop shaper resolves one remainder bit per cycle with wrap or mirror and
//  skips the division otherwise; one shaping for the sample and one for each
//  fired cue. A new sample is accepted only after all results of the previous
//  sample have been sent.
//  s_tready is high only while idle. A stalled result holds the sequencer.
//  Reset is synchronous: started flags and prior time clear, registers load
//  their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module cue_schedule_elapsed_timer_unit
    import cset_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] time_value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // [2:0] channel, [34:3] elapsed
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOOP = 3'd1;
    localparam logic [2:0] ST_FIRE = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_CALC = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [CFG_W-1:0]         cue_reg [NUM_CUES/2];
    logic [3:0]               count_reg;
    logic [1:0]               dur_reg;
    logic [1:0]               loop_reg;
    logic signed [TIME_W-1:0] time_reg, time_next;
    logic signed [TIME_W-1:0] looped_reg, looped_next;
    logic signed [TIME_W-1:0] prior_reg, prior_next;
    logic [NUM_CUES-1:0]      started_reg, started_next;
    logic [NUM_CUES-1:0]      mask_reg, mask_next;
    logic [CH_W-1:0]          chan_reg, chan_next;
    logic signed [TIME_W-1:0] elapsed_reg, elapsed_next;
    logic                     last_reg, last_next;

    logic signed [TIME_W-1:0] cue_time [NUM_CUES];
    logic [3:0]               n_w;
    logic signed [TIME_W-1:0] len_w;
    logic                     just_w;
    logic [NUM_CUES-1:0]      now_w;
    logic [NUM_CUES-1:0]      fire_w;
    logic [NUM_CUES-1:0]      low_w;
    logic [CH_W-1:0]          pick_w;
    logic                     prev_b;
    shape_cmd_t               cmd;
    shape_rsp_t               rsp;

    cset_shape_unit u_shape (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rsp     (rsp)
    );

    always_comb begin
        for (int i = 0; i < NUM_CUES; i++) begin
            cue_time[i] = (i % 2 == 1) ? cue_reg[i/2][63:32] : cue_reg[i/2][31:0];
        end
        n_w   = (count_reg > 4'(NUM_CUES)) ? 4'(NUM_CUES) : count_reg;
        len_w = (n_w == '0) ? '0 : cue_time[CH_W'(n_w - 4'd1)];
    end

    always_comb begin
        just_w = looped_reg < prior_reg;
        for (int i = 0; i < NUM_CUES; i++) begin
            now_w[i]  = (4'(i) < n_w) && (looped_reg >= cue_time[i]);
            prev_b    = (dur_reg == DM_SINGLE && just_w) ? 1'b0 : started_reg[i];
            fire_w[i] = 1'b0;
            if (now_w[i] || prev_b) begin
                case (dur_reg)
                    DM_SINGLE:      fire_w[i] = !prev_b;
                    DM_UNTIL_NEXT:  fire_w[i] = (i == NUM_CUES - 1) ||
                                                !started_reg[(i + 1) % NUM_CUES];
                    DM_UNTIL_RESET: fire_w[i] = 1'b1;
                    default:        fire_w[i] = 1'b0;
                endcase
            end
        end
    end

    always_comb begin
        low_w  = mask_reg & (~mask_reg + 1'b1);
        pick_w = '0;
        for (int i = NUM_CUES - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                pick_w = CH_W'(i);
            end
        end
    end

    always_comb begin
        cmd.start = 1'b0;
        cmd.len   = len_w;
        cmd.mode  = loop_reg;
        if (state_reg == ST_SCAN) begin
            cmd.value = VAL_W'(time_reg) - VAL_W'(cue_time[pick_w]);
        end else begin
            cmd.value = VAL_W'($signed(s_tdata));
        end

        state_next   = state_reg;
        time_next    = time_reg;
        looped_next  = looped_reg;
        prior_next   = prior_reg;
        started_next = started_reg;
        mask_next    = mask_reg;
        chan_next    = chan_reg;
        elapsed_next = elapsed_reg;
        last_next    = last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    time_next  = $signed(s_tdata);
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP: begin
                if (rsp.done) begin
                    looped_next = rsp.result;
                    state_next  = ST_FIRE;
                end
            end
            ST_FIRE: begin
                started_next = now_w;
                prior_next   = looped_reg;
                mask_next    = fire_w;
                state_next   = (fire_w == '0) ? ST_IDLE : ST_SCAN;
            end
            ST_SCAN: begin
                cmd.start  = 1'b1;
                chan_next  = pick_w;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                if (rsp.done) begin
                    elapsed_next = rsp.result;
                    last_next    = (mask_reg & ~low_w) == '0;
                    mask_next    = mask_reg & ~low_w;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = (mask_reg == '0) ? ST_IDLE : ST_SCAN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cue_reg[0]  <= 64'h0002_0000_0001_0000;
            cue_reg[1]  <= '0;
            cue_reg[2]  <= '0;
            cue_reg[3]  <= '0;
            count_reg   <= 4'd2;
            dur_reg     <= DM_UNTIL_RESET;
            loop_reg    <= LM_NONE;
            prior_reg   <= '0;
            started_reg <= '0;
        end else begin
            state_reg   <= state_next;
            prior_reg   <= prior_next;
            started_reg <= started_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_CUE_12:    cue_reg[0] <= cfg_wdata;
                    REG_CUE_34:    cue_reg[1] <= cfg_wdata;
                    REG_CUE_56:    cue_reg[2] <= cfg_wdata;
                    REG_CUE_78:    cue_reg[3] <= cfg_wdata;
                    REG_CUE_COUNT: count_reg  <= cfg_wdata[3:0];
                    REG_DUR_MODE:  dur_reg    <= cfg_wdata[1:0];
                    REG_LOOP_MODE: loop_reg   <= cfg_wdata[1:0];
                    default: begin
                    end
                endcase
            end
        end
        time_reg    <= time_next;
        looped_reg  <= looped_next;
        mask_reg    <= mask_next;
        chan_reg    <= chan_next;
        elapsed_reg <= elapsed_next;
        last_reg    <= last_next;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_OUT;
    assign m_tdata  = {5'd0, elapsed_reg, chan_reg};
    assign m_tlast  = last_reg;

endmodule

/* tb/tb_cue_schedule_elapsed_timer_unit.sv */
// ----------------------------------------------------------------------------
// tb_cue_schedule_elapsed_timer_unit
// Streams 16.16 time samples through the cue timer under a series of cue
// schedules, loop modes and duration modes, predicts the fired cues and their
// elapsed times, and checks every result transfer in order with random idling
// and back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_cue_schedule_elapsed_timer_unit;
    import cset_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] DM_SILENT = 2'd3;
    localparam logic [1:0] LM_SPARE  = 2'd3;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic [2:0]  channel;
        logic [31:0] elapsed;
        logic        last;
    } cue_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;     // [31:0] time_value
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [39:0]          m_tdata;          // [2:0] channel, [34:3] elapsed
    logic                 m_tlast;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    logic [63:0]        cue_bank [4] = '{64'h0002_0000_0001_0000, 64'd0, 64'd0, 64'd0};
    logic [3:0]         cues_used = 4'd2;
    logic [1:0]         dur_mode = DM_UNTIL_RESET;
    logic [1:0]         loop_sel = LM_NONE;
    logic signed [31:0] prior_looped = '0;
    logic [7:0]         cue_on = '0;

    cue_result_t expected_cues [$];

    int  fault_count = 0;
    int  results_seen = 0;
    int  samples_sent = 0;
    int  writes_done = 0;
    bit  src_idle_en = 1'b1;
    bit  sink_idle_en = 1'b1;
    int  hold_request = 0;
    int  hold_left = 0;
    int  stall_left = 0;

    cue_schedule_elapsed_timer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint cue_start(int idx);
        logic [63:0] word;
        word = cue_bank[idx / 2];
        if (idx % 2 == 1) return longint'($signed(word[63:32]));
        return longint'($signed(word[31:0]));
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint span_wrap(longint v, longint m);
        longint lo;
        longint size;
        longint r;
        if (m == 0) return 0;
        lo = (m < 0) ? m : 0;
        size = (m < 0) ? -m : m;
        r = (v - lo) % size;
        if (r < 0) r += size;
        return lo + r;
    endfunction

    function automatic longint loop_shape(longint v, longint len);
        longint w;
        if (loop_sel == LM_WRAP) return span_wrap(v, len);
        if (loop_sel == LM_MIRROR) begin
            w = span_wrap(v, 2 * len);
            if (w > len) w = 2 * len - w;
            return w;
        end
        return v;
    endfunction

    task automatic predict_cues(input logic [31:0] sample);
        longint t;
        longint len;
        longint looped;
        int n;
        logic rolled;
        logic was;
        logic now_on;
        logic fire;
        cue_result_t item;
        cue_result_t batch [$];
        t = longint'($signed(sample));
        n = (cues_used > NUM_CUES) ? NUM_CUES : int'(cues_used);
        len = (n > 0) ? cue_start(n - 1) : 0;
        looped = clamp32(loop_shape(t, len));
        rolled = looped < longint'(prior_looped);
        for (int i = 0; i < NUM_CUES; i++) begin
            if (dur_mode == DM_SINGLE && rolled) cue_on[i] = 1'b0;
            was = cue_on[i];
            now_on = (i < n) && (looped >= cue_start(i));
            fire = 1'b0;
            if (now_on || was != now_on) begin
                case (dur_mode)
                    DM_SINGLE:      fire = !was;
                    DM_UNTIL_NEXT:  fire = (i == NUM_CUES - 1) || !cue_on[i + 1];
                    DM_UNTIL_RESET: fire = 1'b1;
                    default:        fire = 1'b0;
                endcase
            end
            if (fire) begin
                item.channel = 3'(i);
                item.elapsed = 32'(clamp32(loop_shape(t - cue_start(i), len)));
                item.last = 1'b0;
                batch.push_back(item);
            end
            cue_on[i] = now_on;
        end
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k]) expected_cues.push_back(batch[k]);
        prior_looped = 32'(looped);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CUE_12:    cue_bank[0] = value;
            REG_CUE_34:    cue_bank[1] = value;
            REG_CUE_56:    cue_bank[2] = value;
            REG_CUE_78:    cue_bank[3] = value;
            REG_CUE_COUNT: cues_used = value[3:0];
            REG_DUR_MODE:  dur_mode = value[1:0];
            REG_LOOP_MODE: loop_sel = value[1:0];
            default: ;
        endcase
        writes_done++;
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_cues.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_schedule(input logic [7:0][31:0] starts, input logic [3:0] count,
                                input logic [1:0] dur, input logic [1:0] lmode);
        settle();
        write_register(REG_CUE_12, {starts[1], starts[0]});
        write_register(REG_CUE_34, {starts[3], starts[2]});
        write_register(REG_CUE_56, {starts[5], starts[4]});
        write_register(REG_CUE_78, {starts[7], starts[6]});
        write_register(REG_CUE_COUNT, CFG_W'(count));
        write_register(REG_DUR_MODE, CFG_W'(dur));
        write_register(REG_LOOP_MODE, CFG_W'(lmode));
    endtask

    task automatic send_sample(input logic [31:0] value);
        int gap;
        gap = (src_idle_en && $urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        predict_cues(value);
        samples_sent++;
    endtask

    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 7);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cue_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_cues.size() == 0) begin
                if (fault_count < 10)
                    $display("%0t: result with none expected: ch %0d elapsed %h last %b",
                             $time, m_tdata[2:0], m_tdata[34:3], m_tlast);
                fault_count++;
            end else begin
                want = expected_cues.pop_front();
                results_seen++;
                if (m_tdata[2:0] !== want.channel || m_tdata[34:3] !== want.elapsed ||
                    m_tlast !== want.last) begin
                    if (fault_count < 10)
                        $display("%0t: expected ch %0d elapsed %h last %b, got ch %0d elapsed %h last %b",
                                 $time, want.channel, want.elapsed, want.last,
                                 m_tdata[2:0], m_tdata[34:3], m_tlast);
                    fault_count++;
                end
            end
        end
    end

    task automatic test_reset_defaults();
        send_sample(32'h0000_0000);
        send_sample(32'h0000_8000);
        send_sample(32'h0001_8000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'hFFFF_FFFF);
    endtask

    task automatic test_wrap_single();
        set_schedule({32'd0, 32'd0, 32'd0, 32'd0,
                      32'h0004_0000, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000},
                     4'd4, DM_SINGLE, LM_WRAP);
        send_sample(32'h0000_8000);
        send_sample(32'h0001_8000);
        send_sample(32'h0003_8000);
        send_sample(32'h0004_8000);
        send_sample(32'h0005_8000);
        send_sample(-32'sh8000);
    endtask

    task automatic test_mirror_until_next();
        set_schedule({32'd0, 32'd0, 32'd0, 32'd0,
                      32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_0000},
                     4'd4, DM_UNTIL_NEXT, LM_MIRROR);
        send_sample(32'h0000_8000);
        send_sample(32'h0001_8000);
        send_sample(32'h0004_8000);
        send_sample(32'h0007_0000);
    endtask

    task automatic test_odd_settings();
        set_schedule('0, 4'd1, DM_UNTIL_RESET, LM_WRAP);
        send_sample(32'h0012_3456);
        set_schedule({192'd0, -32'sh3_0000, -32'sh1_0000}, 4'd2, DM_UNTIL_RESET, LM_WRAP);
        send_sample(32'h0000_8000);
        settle();
        write_register(REG_LOOP_MODE, CFG_W'(LM_MIRROR));
        send_sample(-32'sh5_0000);
        set_schedule({192'd0, 32'h0002_0000, 32'h0001_0000}, 4'd0, DM_UNTIL_RESET, LM_WRAP);
        send_sample(32'h0001_8000);
        set_schedule({32'h0008_0000, 32'h0007_0000, 32'h0006_0000, 32'h0005_0000,
                      32'h0004_0000, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000},
                     4'd15, DM_UNTIL_RESET, LM_MIRROR);
        send_sample(32'h0009_8000);
        set_schedule({192'd0, 32'h0002_0000, 32'h0001_0000}, 4'd2, DM_SILENT, LM_SPARE);
        send_sample(32'h0003_0000);
    endtask

    task automatic test_count_lowered();
        set_schedule({32'h0001_C000, 32'h0001_8000, 32'h0001_4000, 32'h0001_0000,
                      32'h0000_C000, 32'h0000_8000, 32'h0000_4000, 32'h0000_0000},
                     4'd8, DM_UNTIL_RESET, LM_NONE);
        send_sample(32'h0010_0000);
        settle();
        write_register(REG_CUE_COUNT, CFG_W'(4'd2));
        send_sample(32'h0010_0000);
    endtask

    task automatic test_saturation();
        set_schedule({192'd0, 32'h8000_0000, 32'h7FFF_FFFF}, 4'd2, DM_UNTIL_RESET, LM_NONE);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
    endtask

    task automatic run_random_phase(input int items);
        logic [7:0][31:0] st;
        logic [3:0] count;
        logic [1:0] dur;
        logic [1:0] lmode;
        logic [31:0] t;
        int base;
        base = int'($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
        for (int i = 0; i < NUM_CUES; i++) begin
            st[i] = base;
            base += $urandom_range(32'h2000, 32'h3_0000);
        end
        if ($urandom_range(0, 3) == 0)
            for (int i = 0; i < NUM_CUES; i++) st[i] = -st[i];
        if ($urandom_range(0, 7) == 0)
            for (int i = 0; i < NUM_CUES; i++) st[i] = $urandom;
        count = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
        dur   = ($urandom_range(0, 9) == 0) ? DM_SILENT : 2'($urandom_range(0, 2));
        lmode = ($urandom_range(0, 9) == 0) ? LM_SPARE : 2'($urandom_range(0, 2));
        set_schedule(st, count, dur, lmode);
        t = st[0] - 32'h2_0000;
        repeat (items) begin
            case ($urandom_range(0, 11))
                0:       t = $urandom;
                1:       t = t - $urandom_range(0, 32'h4_0000);
                default: t = t + $urandom_range(32'h800, 32'h1_8000);
            endcase
            send_sample(t);
        end
    endtask

    task automatic test_random_schedules();
        repeat (5) run_random_phase(10);
    endtask

    task automatic test_receiver_hold_off();
        set_schedule({32'h0003_8000, 32'h0003_0000, 32'h0002_8000, 32'h0002_0000,
                      32'h0001_8000, 32'h0001_0000, 32'h0000_8000, 32'h0000_0000},
                     4'd8, DM_UNTIL_RESET, LM_NONE);
        hold_request = 500;
        repeat (6) send_sample(32'h0004_0000 + $urandom_range(0, 32'h10_0000));
    endtask

    task automatic test_sender_pause();
        repeat (3) send_sample(32'h0003_0000 + $urandom_range(0, 32'h2_0000));
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_cues.size() != 0) @(posedge aclk);
        repeat (3) send_sample($urandom_range(0, 32'h5_0000));
    endtask

    task automatic test_steady_stream();
        settle();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        run_random_phase(15);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_wrap_single();
        test_mirror_until_next();
        test_odd_settings();
        test_count_lowered();
        test_saturation();
        test_random_schedules();
        test_receiver_hold_off();
        test_sender_pause();
        test_steady_stream();
        settle();
        $display("Run covered %0d time samples, %0d cue results, %0d register writes,",
                 samples_sent, results_seen, writes_done);
        $display("all loop and duration modes, odd cue counts, saturation and back-pressure.");
        if (fault_count == 0 && expected_cues.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
